### rtl/core/stu_pkg.sv
`default_nettype none

package stu_pkg;

  // Widths of the position counters, of the byte offset, of the token length and of the integer value.
  localparam int unsigned OFFSET_BITS   = 24;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned LEN_BITS      = 16;
  localparam int unsigned VAL_BITS      = 31;

  // Depth of the byte queue, of the record queue, and the record counts per scan step.
  localparam int unsigned IN_DEPTH       = 4;
  localparam int unsigned OUT_DEPTH      = 8;
  localparam int unsigned MAX_STEP_RECS  = 4;
  localparam int unsigned STEP_WRITES    = 4;
  localparam int unsigned WR_N_BITS      = $clog2(STEP_WRITES + 1);

  // Token kinds.
  localparam logic [3:0] KIND_OP      = 4'd0;
  localparam logic [3:0] KIND_KEYWORD = 4'd1;
  localparam logic [3:0] KIND_IDENT   = 4'd2;
  localparam logic [3:0] KIND_STRING  = 4'd3;
  localparam logic [3:0] KIND_INT     = 4'd4;
  localparam logic [3:0] KIND_FLOAT   = 4'd5;
  localparam logic [3:0] KIND_NEWLINE = 4'd6;
  localparam logic [3:0] KIND_INDENT  = 4'd7;
  localparam logic [3:0] KIND_EOF     = 4'd8;
  localparam logic [3:0] KIND_UNKNOWN = 4'd9;
  localparam logic [3:0] KIND_UNTERM  = 4'd10;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_SINGLE = 2'd1,
    CLS_EQ     = 2'd2,
    CLS_DBL    = 2'd3
  } op_cls_e;

  typedef struct packed {
    op_cls_e cls;
    logic    alpha;
    logic    digit;
  } chr_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    chr_t       info;
  } in_item_t;

  typedef struct packed {
    logic [3:0]               kind;
    logic [23:0]              op_text;
    logic [3:0]               keyword_id;
    logic [VAL_BITS-1:0]      value;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] column;
    logic [OFFSET_BITS-1:0]   text_start;
    logic [LEN_BITS-1:0]      text_length;
    logic                     end_of_run;
  } rec_t;

  typedef struct packed {
    logic [WR_N_BITS-1:0]     n;
    rec_t [STEP_WRITES-1:0]   data;
  } rec_wr_t;

  function automatic op_cls_e op_class(logic [7:0] b);
    op_cls_e c;
    unique case (b) inside
      "[", "]", "(", ")", "{", "}", ":", ",", ".", "\\": c = CLS_SINGLE;
      "+", "-", "/", "%", "&", "|", "!", "^", "~", "=":  c = CLS_EQ;
      "<", ">", "*":                                     c = CLS_DBL;
      default:                                           c = CLS_NONE;
    endcase
    return c;
  endfunction

  function automatic chr_t classify(logic [7:0] b);
    chr_t r;
    r.cls   = op_class(b);
    r.alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b == "_");
    r.digit = (b >= "0" && b <= "9");
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/stu_front.sv
`default_nettype none

module stu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       ch_i,
  input  logic             last_i,
  input  logic             push_i,
  output logic             full_o,
  output logic             valid_o,
  output stu_pkg::in_item_t item_o,
  input  logic             take_i
);
  import stu_pkg::*;

  localparam int unsigned PTR_W = $clog2(IN_DEPTH);
  localparam int unsigned CNT_W = $clog2(IN_DEPTH + 1);

  in_item_t         mem_q [IN_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CNT_W'(IN_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = take_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  // Bytes are classified on the way in so the scanner sees the class ready.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= '{ch: ch_i, last: last_i, info: classify(ch_i)};
    end
  end

endmodule

`default_nettype wire

### rtl/core/stu_back.sv
`default_nettype none

module stu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  stu_pkg::in_item_t in_item_i,
  output logic              in_take_o,
  input  logic              room_i,
  output stu_pkg::rec_wr_t  wr_o
);
  import stu_pkg::*;

  localparam int unsigned OFF_W = OFFSET_BITS;
  localparam int unsigned POS_W = POSITION_BITS;
  localparam int unsigned SUM_W = ((POS_W > LEN_BITS) ? POS_W : LEN_BITS) + 1;
  localparam int unsigned LEN1  = LEN_BITS + 1;
  localparam int unsigned PROD_W = VAL_BITS + 4;
  localparam int unsigned KW_N  = 9;
  localparam int unsigned GRP_W = 4;
  localparam logic [POS_W-1:0]    POS_MAX = '1;
  localparam logic [POS_W-1:0]    POS_ONE = POS_W'(1);
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
  localparam logic [VAL_BITS-1:0] VAL_MAX = '1;

  typedef enum logic [4:0] {
    M_IDLE   = 5'b00001,
    M_OP     = 5'b00010,
    M_IDENT  = 5'b00100,
    M_NUMBER = 5'b01000,
    M_STRING = 5'b10000
  } mode_e;

  typedef struct packed {
    mode_e               mode;
    logic [7:0]          la_c1;
    logic [7:0]          la_c2;
    logic [1:0]          la_cnt;
    logic [7:0]          quote;
    logic [OFF_W-1:0]    tok_start;
    logic [LEN_BITS-1:0] tok_len;
    logic [VAL_BITS-1:0] acc;
    logic                seen_dot;
    logic [KW_N-1:0]     kw;
    logic [POS_W-1:0]    line;
    logic [POS_W-1:0]    col;
    logic [OFF_W-1:0]    offset;
    logic [7:0]          prev;
    logic                in_run;
    logic [LEN_BITS-1:0] ind_w;
    logic [OFF_W-1:0]    run_start;
    logic [LEN_BITS-1:0] run_bytes;
    logic [POS_W-1:0]    run_col;
  } st_t;

  typedef struct packed {
    logic [7:0]       b;
    logic [OFF_W-1:0] off;
    logic [7:0]       prev;
  } rp_t;

  typedef struct packed {
    logic [23:0] text;
    logic [1:0]  n;
  } op_t;

  localparam st_t ST_CLEAR = '{
    mode: M_IDLE, la_c1: '0, la_c2: '0, la_cnt: '0, quote: '0, tok_start: '0,
    tok_len: '0, acc: '0, seen_dot: 1'b0, kw: '1, line: POS_ONE, col: POS_ONE,
    offset: '0, prev: '0, in_run: 1'b0, ind_w: '0, run_start: '0, run_bytes: '0,
    run_col: '0};

  function automatic logic [LEN_BITS-1:0] len_inc(logic [LEN_BITS-1:0] a, logic [2:0] n);
    logic [LEN1-1:0] s;
    s = LEN1'(a) + LEN1'(n);
    return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_add(logic [POS_W-1:0] a, logic [LEN_BITS-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(n);
    return (s > SUM_W'(POS_MAX)) ? POS_MAX : s[POS_W-1:0];
  endfunction

  // Keyword text is stored with the first character in the low byte.
  function automatic logic [7:0] kw_char(logic [3:0] k, logic [2:0] p);
    logic [63:0] t;
    unique case (k)
      4'd0:    t = 64'("fi");
      4'd1:    t = 64'("esle");
      4'd2:    t = 64'("elihw");
      4'd3:    t = 64'("rof");
      4'd4:    t = 64'("kaerb");
      4'd5:    t = 64'("eunitnoc");
      4'd6:    t = 64'("nruter");
      4'd7:    t = 64'("eurT");
      4'd8:    t = 64'("eslaF");
      default: t = '0;
    endcase
    return t[8*p +: 8];
  endfunction

  function automatic logic [3:0] kw_len(logic [3:0] k);
    logic [3:0] l;
    unique case (k)
      4'd0:    l = 4'd2;
      4'd1:    l = 4'd4;
      4'd2:    l = 4'd5;
      4'd3:    l = 4'd3;
      4'd4:    l = 4'd5;
      4'd5:    l = 4'd8;
      4'd6:    l = 4'd6;
      4'd7:    l = 4'd4;
      4'd8:    l = 4'd5;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [KW_N-1:0] kw_filter(logic [KW_N-1:0] m, logic [LEN_BITS-1:0] p,
                                                logic [7:0] b);
    logic [KW_N-1:0] r;
    r = m;
    for (int j = 0; j < KW_N; j++) begin
      if (p >= LEN_BITS'(kw_len(4'(j))) || kw_char(4'(j), p[2:0]) != b) begin
        r[j] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic op_t make_op(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3);
    op_t     r;
    op_cls_e c;
    c      = op_class(c1);
    r.text = {16'h0000, c1};
    r.n    = 2'd1;
    if (c == CLS_EQ && c2 == "=") begin
      r.text[15:8] = c2;
      r.n          = 2'd2;
    end
    if (c == CLS_DBL) begin
      if (c2 == "=" || c2 == c1) begin
        r.text[15:8] = c2;
        r.n          = 2'd2;
      end
      if (c3 == "=") begin
        if (r.n == 2'd1) begin
          r.text[15:8] = c3;
        end else begin
          r.text[23:16] = c3;
        end
        r.n = r.n + 2'd1;
      end
    end
    return r;
  endfunction

  function automatic rec_t mk(logic [3:0] kind, logic [23:0] text, logic [3:0] kwid,
                              logic [VAL_BITS-1:0] value, logic [POS_W-1:0] line,
                              logic [POS_W-1:0] col, logic [OFF_W-1:0] start,
                              logic [LEN_BITS-1:0] len);
    return '{kind: kind, op_text: text, keyword_id: kwid, value: value, line: line,
             column: col, text_start: start, text_length: len, end_of_run: 1'b0};
  endfunction

  function automatic rec_t ident_rec(st_t s);
    logic       hit;
    logic [3:0] id;
    hit = 1'b0;
    id  = '0;
    for (int j = KW_N - 1; j >= 0; j--) begin
      if (s.kw[j] && s.tok_len == LEN_BITS'(kw_len(4'(j)))) begin
        hit = 1'b1;
        id  = 4'(j);
      end
    end
    return hit ? mk(KIND_KEYWORD, '0, id, '0, s.line, s.col, s.tok_start, s.tok_len)
               : mk(KIND_IDENT, '0, '0, '0, s.line, s.col, s.tok_start, s.tok_len);
  endfunction

  function automatic rec_t number_rec(st_t s);
    return s.seen_dot ? mk(KIND_FLOAT, '0, '0, '0, s.line, s.col, s.tok_start, s.tok_len)
                      : mk(KIND_INT, '0, '0, s.acc, s.line, s.col, s.tok_start, s.tok_len);
  endfunction

  st_t              st_q, st_d;
  rp_t              rp_q [2];
  logic [1:0]       rp_cnt_q;
  logic             fin_q;
  rec_t             stage_q;
  logic             stage_v_q;
  logic [GRP_W-1:0] grp_q;

  logic act_rp, act_fin, act_in, go, end_step, fin_done;
  rp_t  rp_new [2];
  logic [1:0] rp_new_n;
  rec_t r [3];
  logic [1:0] k;

  assign act_rp    = (rp_cnt_q != 2'd0);
  assign act_fin   = !act_rp && fin_q;
  assign act_in    = !act_rp && !fin_q && in_valid_i;
  assign go        = room_i && (act_rp || act_fin || act_in);
  assign in_take_o = go && act_in;

  // One scan step: a feed of one byte, new or handed back for rescanning, or one pass of the end-of-source flush.
  always_comb begin
    st_t        s;
    logic [7:0] fb, fprev, c1, c2, c2e;
    logic [OFF_W-1:0] foff;
    chr_t       fi;
    logic       do_start;
    op_t        op;
    logic [PROD_W-1:0] prod;

    s        = st_q;
    c1       = st_q.la_c1;
    c2       = st_q.la_c2;
    c2e      = '0;
    k        = 2'd0;
    r[0]     = '0;
    r[1]     = '0;
    r[2]     = '0;
    rp_new[0] = '0;
    rp_new[1] = '0;
    rp_new_n = 2'd0;
    fin_done = 1'b0;
    do_start = 1'b0;
    op       = '0;
    prod     = '0;
    if (act_rp) begin
      fb    = rp_q[0].b;
      foff  = rp_q[0].off;
      fprev = rp_q[0].prev;
      fi    = classify(rp_q[0].b);
    end else begin
      fb    = in_item_i.ch;
      foff  = st_q.offset;
      fprev = st_q.prev;
      fi    = in_item_i.info;
    end

    if (act_fin) begin
      unique case (s.mode)
        M_OP: begin
          c2e = (s.la_cnt == 2'd2) ? c2 : 8'h00;
          op  = make_op(c1, c2e, 8'h00);
          r[k] = mk(KIND_OP, op.text, '0, '0, s.line, s.col, s.tok_start, LEN_BITS'(op.n));
          k    = k + 2'd1;
          s.col = pos_add(s.col, LEN_BITS'(op.n));
          s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
          if (c2e != 8'h00 && op.n == 2'd1) begin
            rp_new[0] = '{b: c2e, off: s.tok_start + OFF_W'(1), prev: c1};
            rp_new_n  = 2'd1;
          end
        end
        M_IDENT: begin
          r[k] = ident_rec(s);
          k    = k + 2'd1;
          s.col = pos_add(s.col, s.tok_len);
          s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
        end
        M_NUMBER: begin
          r[k] = number_rec(s);
          k    = k + 2'd1;
          s.col = pos_add(s.col, s.tok_len);
          s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
        end
        M_STRING: begin
          r[k] = mk(KIND_UNTERM, '0, '0, '0, s.line, s.col, s.tok_start,
                    len_inc(s.tok_len, 3'd1));
          k    = k + 2'd1;
          s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
        end
        default: begin
          if (s.in_run) begin
            r[k] = mk(KIND_INDENT, '0, '0, VAL_BITS'(s.ind_w), s.line, s.run_col,
                      s.run_start, s.run_bytes);
            k    = k + 2'd1;
          end
          r[k] = mk(KIND_EOF, '0, '0, '0, s.line, s.col, s.offset, '0);
          k    = k + 2'd1;
          s        = ST_CLEAR;
          fin_done = 1'b1;
        end
      endcase
    end else begin
      if (act_in) begin
        s.offset = st_q.offset + OFF_W'(1);
        s.prev   = fb;
      end
      unique case (s.mode)
        M_IDENT: begin
          if (fi.alpha || fi.digit) begin
            s.kw      = kw_filter(s.kw, s.tok_len, fb);
            s.tok_len = len_inc(s.tok_len, 3'd1);
          end else begin
            r[k] = ident_rec(s);
            k    = k + 2'd1;
            s.col = pos_add(s.col, s.tok_len);
            s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
            do_start = 1'b1;
          end
        end
        M_NUMBER: begin
          if (fb == "." && !s.seen_dot) begin
            s.seen_dot = 1'b1;
            s.tok_len  = len_inc(s.tok_len, 3'd1);
          end else if (fi.digit) begin
            s.tok_len = len_inc(s.tok_len, 3'd1);
            if (!s.seen_dot) begin
              prod  = (PROD_W'(s.acc) << 3) + (PROD_W'(s.acc) << 1) + PROD_W'(fb - 8'h30);
              s.acc = (prod > PROD_W'(VAL_MAX)) ? VAL_MAX : prod[VAL_BITS-1:0];
            end
          end else begin
            r[k] = number_rec(s);
            k    = k + 2'd1;
            s.col = pos_add(s.col, s.tok_len);
            s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
            do_start = 1'b1;
          end
        end
        M_STRING: begin
          if (fb == s.quote) begin
            r[k] = mk(KIND_STRING, '0, '0, '0, s.line, s.col, s.tok_start + OFF_W'(1),
                      s.tok_len);
            k    = k + 2'd1;
            s.col = pos_add(s.col, len_inc(s.tok_len, 3'd1));
            s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
          end else begin
            s.tok_len = len_inc(s.tok_len, 3'd1);
          end
        end
        M_OP: begin
          if (s.la_cnt == 2'd1 && op_class(c1) == CLS_DBL) begin
            s.la_c2  = fb;
            s.la_cnt = 2'd2;
          end else if (s.la_cnt == 2'd2) begin
            op   = make_op(c1, c2, fb);
            r[k] = mk(KIND_OP, op.text, '0, '0, s.line, s.col, s.tok_start, LEN_BITS'(op.n));
            k    = k + 2'd1;
            s.col = pos_add(s.col, LEN_BITS'(op.n));
            s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
            // Bytes the operator did not take are scanned again in later cycles.
            if (op.n == 2'd1) begin
              rp_new[0] = '{b: c2, off: foff - OFF_W'(1), prev: c1};
              rp_new[1] = '{b: fb, off: foff, prev: c2};
              rp_new_n  = 2'd2;
            end else if (op.n == 2'd2) begin
              rp_new[0] = '{b: fb, off: foff, prev: c2};
              rp_new_n  = 2'd1;
            end
          end else begin
            op   = make_op(c1, fb, 8'h00);
            r[k] = mk(KIND_OP, op.text, '0, '0, s.line, s.col, s.tok_start, LEN_BITS'(op.n));
            k    = k + 2'd1;
            s.col = pos_add(s.col, LEN_BITS'(op.n));
            s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
            do_start = (op.n != 2'd2);
          end
        end
        default: begin
          s.mode = M_IDLE; s.la_cnt = '0; s.la_c1 = '0; s.la_c2 = '0;
          do_start = 1'b1;
        end
      endcase

      if (do_start) begin
        if (fb == " ") begin
          if (s.in_run) begin
            s.ind_w     = len_inc(s.ind_w, 3'd1);
            s.run_bytes = len_inc(s.run_bytes, 3'd1);
            s.col       = pos_add(s.col, LEN_BITS'(1));
          end else if (fprev == " ") begin
            s.in_run    = 1'b1;
            s.ind_w     = LEN_BITS'(2);
            s.run_bytes = LEN_BITS'(2);
            s.run_start = foff - OFF_W'(1);
            s.run_col   = s.col;
            s.col       = pos_add(s.col, LEN_BITS'(1));
          end
        end else if (fb == "\t") begin
          if (s.in_run) begin
            s.ind_w     = len_inc(s.ind_w, 3'd4);
            s.run_bytes = len_inc(s.run_bytes, 3'd1);
          end else begin
            s.in_run    = 1'b1;
            s.ind_w     = LEN_BITS'(4);
            s.run_bytes = LEN_BITS'(1);
            s.run_start = foff;
            s.run_col   = s.col;
          end
          s.col = pos_add(s.col, LEN_BITS'(3));
        end else begin
          if (s.in_run) begin
            r[k] = mk(KIND_INDENT, '0, '0, VAL_BITS'(s.ind_w), s.line, s.run_col,
                      s.run_start, s.run_bytes);
            k    = k + 2'd1;
            s.in_run = 1'b0;
          end
          if (fi.cls == CLS_SINGLE) begin
            r[k] = mk(KIND_OP, {16'h0000, fb}, '0, '0, s.line, s.col, foff, LEN_BITS'(1));
            k    = k + 2'd1;
            s.col = pos_add(s.col, LEN_BITS'(1));
          end else if (fi.cls != CLS_NONE) begin
            s.mode      = M_OP;
            s.la_c1     = fb;
            s.la_c2     = '0;
            s.la_cnt    = 2'd1;
            s.tok_start = foff;
          end else if (fi.alpha) begin
            s.mode      = M_IDENT;
            s.tok_start = foff;
            s.tok_len   = LEN_BITS'(1);
            s.kw        = kw_filter('1, '0, fb);
          end else if (fi.digit) begin
            s.mode      = M_NUMBER;
            s.tok_start = foff;
            s.tok_len   = LEN_BITS'(1);
            s.acc       = VAL_BITS'(fb - 8'h30);
            s.seen_dot  = 1'b0;
          end else if (fb == "\"" || fb == "'") begin
            s.mode      = M_STRING;
            s.quote     = fb;
            s.tok_start = foff;
            s.tok_len   = '0;
          end else if (fb == "\n") begin
            r[k] = mk(KIND_NEWLINE, '0, '0, '0, s.line, s.col, foff, LEN_BITS'(1));
            k    = k + 2'd1;
            s.line = pos_add(s.line, LEN_BITS'(1));
            s.col  = POS_ONE;
          end else begin
            r[k] = mk(KIND_UNKNOWN, '0, '0, '0, s.line, s.col, foff, LEN_BITS'(1));
            k    = k + 2'd1;
            s.col = pos_add(s.col, LEN_BITS'(1));
          end
        end
      end
    end
    st_d = s;
  end

  assign end_step = go && ((act_in && !in_item_i.last && rp_new_n == 2'd0) ||
                           (act_rp && rp_cnt_q == 2'd1 && !fin_q) ||
                           (act_fin && fin_done));

  // The newest record waits in a staging register until it is known whether it
  // closes the group of records that one byte returns.
  rec_t [STEP_WRITES-1:0] cand;
  logic [2:0]       nc;
  logic [1:0]       last_idx;
  logic [GRP_W-1:0] grp_n, grp_d;
  rec_t             stage_d;
  logic             stage_v_d;

  always_comb begin
    cand = '0;
    nc   = 3'd0;
    if (stage_v_q) begin
      cand[0] = stage_q;
      nc      = 3'd1;
    end
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < k) begin
        cand[nc[1:0]] = r[i];
        nc            = nc + 3'd1;
      end
    end
    last_idx  = 2'(nc - 3'd1);
    grp_n     = grp_q + GRP_W'(k);
    wr_o      = '0;
    wr_o.data = cand;
    stage_d   = stage_q;
    stage_v_d = stage_v_q;
    grp_d     = grp_q;
    if (go) begin
      if (end_step && grp_n <= GRP_W'(MAX_STEP_RECS)) begin
        if (nc != 3'd0) begin
          wr_o.data[last_idx].end_of_run = 1'b1;
        end
        wr_o.n    = WR_N_BITS'(nc);
        stage_v_d = 1'b0;
        grp_d     = '0;
      end else begin
        if (nc != 3'd0) begin
          wr_o.n    = WR_N_BITS'(nc - 3'd1);
          stage_d   = cand[last_idx];
          stage_v_d = 1'b1;
        end
        grp_d = end_step ? grp_n - GRP_W'(MAX_STEP_RECS) : grp_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLEAR;
      rp_cnt_q  <= 2'd0;
      fin_q     <= 1'b0;
      stage_v_q <= 1'b0;
      grp_q     <= '0;
    end else if (go) begin
      st_q      <= st_d;
      stage_v_q <= stage_v_d;
      grp_q     <= grp_d;
      if (act_rp) begin
        rp_cnt_q <= rp_cnt_q - 2'd1;
      end else begin
        rp_cnt_q <= rp_new_n;
      end
      if (act_in && in_item_i.last) begin
        fin_q <= 1'b1;
      end else if (fin_done) begin
        fin_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      stage_q <= stage_d;
      if (act_rp) begin
        rp_q[0] <= rp_q[1];
      end else begin
        rp_q[0] <= rp_new[0];
        rp_q[1] <= rp_new[1];
      end
    end
  end

  a_stage_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_v_q == (grp_q != '0))
    else $error("staged record and group count disagree");

  a_no_nested_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && act_rp) |-> (rp_new_n == 2'd0))
    else $error("rescanned byte asked for a further rescan");

  a_rp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_cnt_q != 2'd3)
    else $error("rescan queue overflow");

  a_fin_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !in_take_o)
    else $error("byte taken while end of source is being flushed");

endmodule

`default_nettype wire

### rtl/core/stu_outq.sv
`default_nettype none

module stu_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stu_pkg::rec_wr_t wr_i,
  output logic             room_o,
  output logic             empty_o,
  input  logic             pop_i,
  output stu_pkg::rec_t    rec_o
);
  import stu_pkg::*;

  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

  rec_t             mem_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rd_en;

  assign empty_o = (cnt_q == '0);
  assign room_o  = (cnt_q <= CNT_W'(OUT_DEPTH - STEP_WRITES));
  assign rec_o   = mem_q[rd_ptr_q];
  assign rd_en   = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(wr_i.n);
      cnt_q    <= cnt_q + CNT_W'(wr_i.n) - CNT_W'(rd_en);
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STEP_WRITES; i++) begin
      if (WR_N_BITS'(i) < wr_i.n) begin
        mem_q[wr_ptr_q + PTR_W'(i)] <= wr_i.data[i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/source_tokenizer_unit.sv
// Streaming source tokenizer. Source bytes enter through a queue-style port (push/full),
// one byte per request with a mark on the final byte, and token records leave through a
// second queue-style port (empty/pop), oldest first. The scanner performs one scan step
// per cycle while the record queue has room. A step feeds one new byte, rescans a byte
// that an operator hands back when it declines its lookahead (one or two bytes), or runs
// one pass of the flush after the final byte, which closes a token still open or, once
// none is, adds the indentation/end-of-file record. The record queue must have four
// free slots before a step may run and drains one record per pop.
`default_nettype none

module source_tokenizer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [7:0]                         ch_i,
  input  logic                               last_i,
  input  logic                               push,
  output logic                               full,
  output logic                               empty,
  input  logic                               pop,
  output logic [3:0]                         kind_o,
  output logic [23:0]                        op_text_o,
  output logic [3:0]                         keyword_id_o,
  output logic [stu_pkg::VAL_BITS-1:0]       value_o,
  output logic [stu_pkg::POSITION_BITS-1:0]  line_o,
  output logic [stu_pkg::POSITION_BITS-1:0]  column_o,
  output logic [stu_pkg::OFFSET_BITS-1:0]    text_start_o,
  output logic [stu_pkg::LEN_BITS-1:0]       text_length_o,
  output logic                               end_of_run_o
);
  import stu_pkg::*;

  in_item_t item;
  logic     item_valid, item_take, room;
  rec_wr_t  rec_wr;
  rec_t     rec;

  // The front end queues and classifies incoming bytes.
  stu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ch_i    (ch_i),
    .last_i  (last_i),
    .push_i  (push),
    .full_o  (full),
    .valid_o (item_valid),
    .item_o  (item),
    .take_i  (item_take)
  );

  // The scanner runs the token state machine and groups records per byte.
  stu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_valid),
    .in_item_i  (item),
    .in_take_o  (item_take),
    .room_i     (room),
    .wr_o       (rec_wr)
  );

  // The record queue decouples the scanner from the consumer.
  stu_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (rec_wr),
    .room_o  (room),
    .empty_o (empty),
    .pop_i   (pop),
    .rec_o   (rec)
  );

  assign kind_o        = rec.kind;
  assign op_text_o     = rec.op_text;
  assign keyword_id_o  = rec.keyword_id;
  assign value_o       = rec.value;
  assign line_o        = rec.line;
  assign column_o      = rec.column;
  assign text_start_o  = rec.text_start;
  assign text_length_o = rec.text_length;
  assign end_of_run_o  = rec.end_of_run;

endmodule

`default_nettype wire

### test/tb_top.sv
`default_nettype none

// Self-checking bench for the streaming source tokenizer.
// Source bytes are offered on the push/full side with random gaps. The results
// are drained on the empty/pop side with random stalls. Every accepted byte is
// run through a behavioral tokenizer kept inside the bench. That tokenizer
// appends the records it expects to a FIFO. Each popped record is compared,
// field by field, against the oldest entry in that FIFO.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stu_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and the signals at the block's ports.
  // ---------------------------------------------------------------------------
  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  ch_i   = 8'd0;
  logic        last_i = 1'b0;
  logic        push   = 1'b0;
  logic        pop    = 1'b0;
  logic        full;
  logic        empty;
  logic [3:0]  kind_o;
  logic [23:0] op_text_o;
  logic [3:0]  keyword_id_o;
  logic [VAL_BITS-1:0]      value_o;
  logic [POSITION_BITS-1:0] line_o;
  logic [POSITION_BITS-1:0] column_o;
  logic [OFFSET_BITS-1:0]   text_start_o;
  logic [LEN_BITS-1:0]      text_length_o;
  logic                     end_of_run_o;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  source_tokenizer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ch_i          (ch_i),
    .last_i        (last_i),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .op_text_o     (op_text_o),
    .keyword_id_o  (keyword_id_o),
    .value_o       (value_o),
    .line_o        (line_o),
    .column_o      (column_o),
    .text_start_o  (text_start_o),
    .text_length_o (text_length_o),
    .end_of_run_o  (end_of_run_o)
  );

  // ---------------------------------------------------------------------------
  // Behavioral tokenizer. It works on its own copy of the scanner state.
  // ---------------------------------------------------------------------------
  typedef enum int {SCAN_IDLE, SCAN_OP, SCAN_IDENT, SCAN_NUM, SCAN_STR} scan_e;

  localparam int unsigned OFF_MASK  = (1 << OFFSET_BITS) - 1;
  localparam int unsigned POS_LIMIT = (1 << POSITION_BITS) - 1;
  localparam int unsigned LEN_LIMIT = 16'hFFFF;
  localparam int unsigned VAL_LIMIT = 32'h7FFF_FFFF;
  localparam int          HELD_CAP  = 8;

  string kw_word [9] = '{"if", "else", "while", "for", "break", "continue", "return",
                          "True", "False"};

  logic [15:0] la_bytes;
  int unsigned la_cnt;
  scan_e       mode;
  logic [7:0]  quote_ch;
  int unsigned tok_start, tok_len, num_acc;
  bit          seen_dot;
  logic [8:0]  kw_mask;
  int unsigned line_cnt, col_cnt, src_off;
  logic [7:0]  prev_ch;
  bit          in_indent;
  int unsigned ind_width, run_start, run_bytes, run_col;
  rec_t        held_recs[$];   // records produced but not yet released
  rec_t        token_fifo[$];  // records the block is expected to deliver
  logic [3:0]  first_kind;     // kind of the first record released by the last step
  int          step_recs;

  function automatic int unsigned sat_add(int unsigned a, int unsigned b, int unsigned lim);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > lim) ? lim : int'(s);
  endfunction

  function automatic void col_adv(int unsigned n);
    col_cnt = sat_add(col_cnt, n, POS_LIMIT);
  endfunction

  function automatic void add_rec(logic [3:0] kind, int unsigned optext, int unsigned kw,
                                  int unsigned val, int unsigned col, int unsigned start,
                                  int unsigned len);
    rec_t r;
    if (held_recs.size() >= HELD_CAP) return;
    r.kind        = kind;
    r.op_text     = optext[23:0];
    r.keyword_id  = kw[3:0];
    r.value       = val[VAL_BITS-1:0];
    r.line        = line_cnt[POSITION_BITS-1:0];
    r.column      = col[POSITION_BITS-1:0];
    r.text_start  = start[OFFSET_BITS-1:0];
    r.text_length = (len > LEN_LIMIT) ? LEN_LIMIT[15:0] : len[15:0];
    r.end_of_run  = 1'b0;
    held_recs = {held_recs, r};
  endfunction

  function automatic op_cls_e op_group(logic [7:0] b);
    case (b)
      "[", "]", "(", ")", "{", "}", ":", ",", ".", "\\": return CLS_SINGLE;
      "+", "-", "/", "%", "&", "|", "!", "^", "~", "=":  return CLS_EQ;
      "<", ">", "*":                                     return CLS_DBL;
      default:                                           return CLS_NONE;
    endcase
  endfunction

  // Packs an operator from up to three bytes; n returns how many it takes.
  function automatic int unsigned pack_op(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
                                          output int unsigned n);
    int unsigned text;
    op_cls_e     g;
    text = 32'(c1);
    n    = 1;
    g    = op_group(c1);
    if (g == CLS_EQ && c2 == "=") begin
      text |= int'(c2) << 8;
      n = 2;
    end
    if (g == CLS_DBL) begin
      if (c2 == "=" || c2 == c1) begin
        text |= int'(c2) << (8 * n);
        n++;
      end
      if (c3 == "=") begin
        text |= int'(c3) << (8 * n);
        n++;
      end
    end
    return text;
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void narrow_keywords(int unsigned p, logic [7:0] b);
    for (int k = 0; k < 9; k++)
      if (p >= kw_word[k].len() || kw_word[k][p] != b) kw_mask[k] = 1'b0;
  endfunction

  function automatic void scan_idle();
    mode     = SCAN_IDLE;
    la_cnt   = 0;
    la_bytes = 16'd0;
  endfunction

  function automatic void close_word();
    int id;
    id = -1;
    for (int k = 0; k < 9 && id < 0; k++)
      if (kw_mask[k] && tok_len == kw_word[k].len()) id = k;
    if (id >= 0) add_rec(KIND_KEYWORD, 0, id, 0, col_cnt, tok_start, tok_len);
    else add_rec(KIND_IDENT, 0, 0, 0, col_cnt, tok_start, tok_len);
    col_adv(tok_len);
    scan_idle();
  endfunction

  function automatic void close_number();
    if (seen_dot) add_rec(KIND_FLOAT, 0, 0, 0, col_cnt, tok_start, tok_len);
    else add_rec(KIND_INT, 0, 0, num_acc, col_cnt, tok_start, tok_len);
    col_adv(tok_len);
    scan_idle();
  endfunction

  function automatic void close_indent();
    if (!in_indent) return;
    add_rec(KIND_INDENT, 0, 0, ind_width, run_col, run_start, run_bytes);
    in_indent = 1'b0;
  endfunction

  // A byte seen while no token is open.
  function automatic void open_token(logic [7:0] b, int unsigned off, logic [7:0] pb);
    op_cls_e g;
    if (b == " ") begin
      if (in_indent) begin
        ind_width = sat_add(ind_width, 1, LEN_LIMIT);
        run_bytes = sat_add(run_bytes, 1, LEN_LIMIT);
        col_adv(1);
      end else if (pb == " ") begin
        // A second space in a row opens an indentation run of width two.
        in_indent = 1'b1;
        ind_width = 2;
        run_bytes = 2;
        run_start = (off - 1) & OFF_MASK;
        run_col   = col_cnt;
        col_adv(1);
      end
      return;
    end
    if (b == "\t") begin
      if (in_indent) begin
        ind_width = sat_add(ind_width, 4, LEN_LIMIT);
        run_bytes = sat_add(run_bytes, 1, LEN_LIMIT);
      end else begin
        in_indent = 1'b1;
        ind_width = 4;
        run_bytes = 1;
        run_start = off;
        run_col   = col_cnt;
      end
      col_adv(3);
      return;
    end
    close_indent();
    g = op_group(b);
    if (g == CLS_SINGLE) begin
      add_rec(KIND_OP, 32'(b), 0, 0, col_cnt, off, 1);
      col_adv(1);
    end else if (g != CLS_NONE) begin
      mode      = SCAN_OP;
      la_bytes  = {8'd0, b};
      la_cnt    = 1;
      tok_start = off;
    end else if (is_letter(b)) begin
      mode      = SCAN_IDENT;
      tok_start = off;
      tok_len   = 1;
      kw_mask   = 9'h1FF;
      narrow_keywords(0, b);
    end else if (is_num(b)) begin
      mode      = SCAN_NUM;
      tok_start = off;
      tok_len   = 1;
      num_acc   = 32'(b - "0");
      seen_dot  = 1'b0;
    end else if (b == "\"" || b == "'") begin
      mode      = SCAN_STR;
      quote_ch  = b;
      tok_start = off;
      tok_len   = 0;
    end else if (b == "\n") begin
      add_rec(KIND_NEWLINE, 0, 0, 0, col_cnt, off, 1);
      line_cnt = sat_add(line_cnt, 1, POS_LIMIT);
      col_cnt  = 1;
    end else begin
      add_rec(KIND_UNKNOWN, 0, 0, 0, col_cnt, off, 1);
      col_adv(1);
    end
  endfunction

  // One byte into the scanner. Bytes that an operator hands back are fed again.
  function automatic void scan_byte(logic [7:0] b, int unsigned off, logic [7:0] pb);
    logic [7:0]      c1, c2;
    int unsigned     text, n;
    longint unsigned acc;
    c1 = la_bytes[7:0];
    c2 = la_bytes[15:8];
    case (mode)
      SCAN_IDENT: begin
        if (is_letter(b) || is_num(b)) begin
          narrow_keywords(tok_len, b);
          tok_len = sat_add(tok_len, 1, LEN_LIMIT);
          return;
        end
        close_word();
      end
      SCAN_NUM: begin
        if (b == "." && !seen_dot) begin
          seen_dot = 1'b1;
          tok_len  = sat_add(tok_len, 1, LEN_LIMIT);
          return;
        end
        if (is_num(b)) begin
          tok_len = sat_add(tok_len, 1, LEN_LIMIT);
          if (!seen_dot) begin
            acc     = longint'(num_acc) * 10 + 64'(b - "0");
            num_acc = (acc > VAL_LIMIT) ? VAL_LIMIT : int'(acc);
          end
          return;
        end
        close_number();
      end
      SCAN_STR: begin
        if (b == quote_ch) begin
          add_rec(KIND_STRING, 0, 0, 0, col_cnt, tok_start + 1, tok_len);
          col_adv(sat_add(tok_len, 1, LEN_LIMIT));
          scan_idle();
        end else begin
          tok_len = sat_add(tok_len, 1, LEN_LIMIT);
        end
        return;
      end
      SCAN_OP: begin
        if (la_cnt == 1 && op_group(c1) == CLS_DBL) begin
          la_bytes = {b, c1};
          la_cnt   = 2;
          return;
        end
        if (la_cnt == 2) begin
          text = pack_op(c1, c2, b, n);
          add_rec(KIND_OP, text, 0, 0, col_cnt, tok_start, n);
          col_adv(n);
          scan_idle();
          if (n == 1) begin
            scan_byte(c2, (off - 1) & OFF_MASK, c1);
            scan_byte(b, off, c2);
          end else if (n == 2) begin
            scan_byte(b, off, c2);
          end
          return;
        end
        text = pack_op(c1, b, 8'd0, n);
        add_rec(KIND_OP, text, 0, 0, col_cnt, tok_start, n);
        col_adv(n);
        scan_idle();
        if (n == 2) return;
      end
      default: scan_idle();
    endcase
    open_token(b, off, pb);
  endfunction

  // Closes any open token or indentation run, then adds the end-of-file record.
  function automatic void close_source();
    logic [7:0]  c1, c2;
    int unsigned text, n;
    while (mode != SCAN_IDLE) begin
      case (mode)
        SCAN_OP: begin
          c1   = la_bytes[7:0];
          c2   = (la_cnt == 2) ? la_bytes[15:8] : 8'd0;
          text = pack_op(c1, c2, 8'd0, n);
          add_rec(KIND_OP, text, 0, 0, col_cnt, tok_start, n);
          col_adv(n);
          scan_idle();
          if (c2 != 0 && n == 1) scan_byte(c2, (tok_start + 1) & OFF_MASK, c1);
        end
        SCAN_IDENT: close_word();
        SCAN_NUM:   close_number();
        SCAN_STR: begin
          add_rec(KIND_UNTERM, 0, 0, 0, col_cnt, tok_start, sat_add(tok_len, 1, LEN_LIMIT));
          scan_idle();
        end
        default: scan_idle();
      endcase
    end
    close_indent();
    add_rec(KIND_EOF, 0, 0, 0, col_cnt, src_off, 0);
  endfunction

  function automatic void clear_source();
    scan_idle();
    quote_ch  = 8'd0;
    tok_start = 0;
    tok_len   = 0;
    num_acc   = 0;
    seen_dot  = 1'b0;
    kw_mask   = 9'h1FF;
    line_cnt  = 1;
    col_cnt   = 1;
    src_off   = 0;
    prev_ch   = 8'd0;
    in_indent = 1'b0;
    ind_width = 0;
    run_start = 0;
    run_bytes = 0;
    run_col   = 0;
  endfunction

  // Accepts one byte, then releases up to four held records into the token FIFO.
  function automatic void tokenize_byte(logic [7:0] b, bit is_last);
    int   total, n;
    rec_t r;
    scan_byte(b, src_off, prev_ch);
    prev_ch = b;
    src_off = (src_off + 1) & OFF_MASK;
    if (is_last) begin
      close_source();
      clear_source();
    end
    total = held_recs.size();
    n     = (total < MAX_STEP_RECS) ? total : MAX_STEP_RECS;
    first_kind = n ? held_recs[0].kind : 4'hF;
    step_recs  = n;
    for (int k = 0; k < n; k++) begin
      r = held_recs.pop_front();
      r.end_of_run = (k == n - 1) && (total == n);
      token_fifo = {token_fifo, r};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------
  int errors   = 0;
  int recs_ok  = 0;
  int bytes_in = 0;
  int sources  = 0;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    errors++;
    if (errors <= 40) $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
  endtask

  task automatic compare_token(rec_t want);
    if (kind_o        !== want.kind)        report("kind", kind_o, want.kind);
    if (op_text_o     !== want.op_text)     report("op_text", op_text_o, want.op_text);
    if (keyword_id_o  !== want.keyword_id)  report("keyword_id", keyword_id_o, want.keyword_id);
    if (value_o       !== want.value)       report("value", value_o, want.value);
    if (line_o        !== want.line)        report("line", line_o, want.line);
    if (column_o      !== want.column)      report("column", column_o, want.column);
    if (text_start_o  !== want.text_start)  report("text_start", text_start_o, want.text_start);
    if (text_length_o !== want.text_length) report("text_length", text_length_o,
                                                   want.text_length);
    if (end_of_run_o  !== want.end_of_run)  report("end_of_run", end_of_run_o, want.end_of_run);
  endtask

  // Result side: a popped record is checked, then the pop for the next cycle is chosen.
  // Most stalls are brief; a few last long enough to fill the queue.
  int  pop_hold = 0;
  bit  pop_calm = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (token_fifo.size() == 0) report("unexpected record, kind", kind_o, 0);
      else begin
        compare_token(token_fifo.pop_front());
        recs_ok++;
      end
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 299) == 0) pop_calm = !pop_calm;
      if (!pop_calm) begin
        if ($urandom_range(0, 29) == 0) pop_hold = $urandom_range(20, 60);
        else if ($urandom_range(0, 4) == 0) pop_hold = $urandom_range(1, 3);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  typedef struct {
    string      txt;
    bit         last;
    bit         chk;   // a kind for the first record of the final byte is typed in
    logic [3:0] kind;
  } src_row_t;

  // Directed sources: keywords versus identifiers, operator lookahead that is
  // taken and declined, spaces and tabs into an indentation run, integer
  // saturation, floats, strings, unknown bytes, an operator cut off by the
  // last byte, and a string left open at the last byte.
  src_row_t directed[] = '{
    '{"x",            1'b1, 1'b1, KIND_IDENT},
    '{"if(",          1'b0, 1'b1, KIND_KEYWORD},
    '{"a<<=b*c<d",    1'b0, 1'b0, KIND_OP},
    '{" \n",          1'b0, 1'b1, KIND_NEWLINE},
    '{"  \tTrue 1.5 ", 1'b0, 1'b0, KIND_OP},
    '{"99999999999>", 1'b0, 1'b0, KIND_OP},
    '{"=\"q\"",       1'b0, 1'b0, KIND_OP},
    '{"?",            1'b0, 1'b1, KIND_UNKNOWN},
    '{"\377",         1'b0, 1'b1, KIND_UNKNOWN},
    '{"*",            1'b1, 1'b1, KIND_OP},
    '{"'ab",          1'b1, 1'b1, KIND_UNTERM}
  };

  logic [7:0] rnd_ch[$];
  bit         rnd_last[$];
  string      op_chars = "+-/%&|!^~=<>*[](){}:,.\\";

  task automatic add_byte(logic [7:0] b);
    rnd_ch   = {rnd_ch, b};
    rnd_last = {rnd_last, 1'b0};
  endtask

  // Random sources: mostly well-formed tokens with random content, plus noise bytes.
  task automatic build_random();
    int    pick, len;
    logic [7:0] q, b;
    while (rnd_ch.size() < 200) begin
      pick = $urandom_range(0, 11);
      case (pick)
        0: begin
          len = $urandom_range(0, 8);
          for (int i = 0; i < kw_word[len].len(); i++) add_byte(kw_word[len][i]);
        end
        1: begin
          len = $urandom_range(1, 6);
          add_byte(8'("a" + $urandom_range(0, 25)));
          for (int i = 1; i < len; i++)
            case ($urandom_range(0, 3))
              0:       add_byte(8'("0" + $urandom_range(0, 9)));
              1:       add_byte("_");
              2:       add_byte(8'("A" + $urandom_range(0, 25)));
              default: add_byte(8'("a" + $urandom_range(0, 25)));
            endcase
        end
        2: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
          for (int i = 0; i < len; i++) add_byte(8'("0" + $urandom_range(0, 9)));
        end
        3: begin
          add_byte(8'("0" + $urandom_range(0, 9)));
          add_byte(".");
          if ($urandom_range(0, 1)) add_byte(8'("0" + $urandom_range(0, 9)));
        end
        4, 5: begin
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++) add_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
        end
        6: begin
          q = $urandom_range(0, 1) ? "\"" : "'";
          add_byte(q);
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            add_byte((b == q) ? "z" : b);
          end
          if ($urandom_range(0, 5) != 0) add_byte(q);
        end
        7: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) add_byte(" ");
        end
        8:  add_byte("\t");
        9:  add_byte("\n");
        10: add_byte(" ");
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 14) == 0) rnd_last[$] = 1'b1;
    end
    rnd_last[$] = 1'b1;
  endtask

  int push_gap;

  // Offers one byte and waits for the block to take it. The gap before the
  // request is random: mostly none or short, now and then long.
  task automatic send_byte(logic [7:0] b, bit is_last);
    case ($urandom_range(0, 19))
      0:          push_gap = $urandom_range(10, 40);
      1, 2, 3, 4: push_gap = $urandom_range(1, 3);
      default:    push_gap = 0;
    endcase
    if (push_gap > 0) begin
      push <= 1'b0;
      repeat (push_gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    ch_i   <= b;
    last_i <= is_last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tokenize_byte(b, is_last);
    bytes_in++;
    if (is_last) sources++;
  endtask

  initial begin
    int drain;
    held_recs.delete();
    token_fifo.delete();
    clear_source();
    build_random();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[r]) begin
      for (int i = 0; i < directed[r].txt.len(); i++)
        send_byte(directed[r].txt[i], directed[r].last && i == directed[r].txt.len() - 1);
      if (directed[r].chk && (step_recs == 0 || first_kind != directed[r].kind))
        report("directed first kind", first_kind, directed[r].kind);
    end

    foreach (rnd_ch[i]) send_byte(rnd_ch[i], rnd_last[i]);
    push <= 1'b0;

    // Wait for every expected record, then a while longer to catch strays.
    while (token_fifo.size() != 0) @(posedge clk_i);
    for (drain = 0; drain < 100; drain++) @(posedge clk_i);

    $display("Fed %0d bytes in %0d sources; %0d token records matched.",
             bytes_in, sources, recs_ok);
    if (errors == 0 && token_fifo.size() == 0) begin
      $display("source_tokenizer_unit test passed");
    end else begin
      $display("source_tokenizer_unit test failed");
    end
    $finish;
  end

  // Time limit for the run, far beyond the slowest legal drain of all stimulus.
  initial begin
    #5_000_000;
    $display("Timeout with %0d records still expected.", token_fifo.size());
    $display("source_tokenizer_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
